FILE: src/ptt_pkg.sv
`default_nettype none

package ptt_pkg;

    // Request codes carried in the input beat
    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_SCHED  = 2'd1,
        ACT_CANCEL = 2'd2
    } action_t;

    // Result codes carried in the output beat
    typedef enum logic [1:0] {
        KIND_EXPIRE = 2'd0,
        KIND_SCHED  = 2'd1,
        KIND_CANCEL = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_MISS = 2'd1,
        STATUS_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    localparam int ID_W  = 16;
    localparam int REP_W = 16;
    localparam int IN_TIME_W = 32;

    typedef struct packed {
        action_t                  action;
        logic [ID_W-1:0]          timer_id;
        logic [IN_TIME_W-1:0]     expiry_time;
        logic [IN_TIME_W-1:0]     period;
        logic signed [REP_W-1:0]  repeat_count;
    } in_beat_t;

    typedef struct packed {
        kind_t           kind;
        logic [ID_W-1:0] timer_id_res;
        status_t         status;
        logic            last;
    } out_beat_t;

    // Flags from the shared key unit
    typedef struct packed {
        logic due;
        logic less;
    } cmp_res_t;

endpackage

`default_nettype wire

FILE: src/ptt_key_unit.sv
`default_nettype none

module ptt_key_unit #(
    parameter int TW = 32
) (
    input  wire logic [TW-1:0] expiry,
    input  wire logic [TW-1:0] now,
    input  wire logic [TW-1:0] best_key,
    output logic [TW-1:0]      key,
    output ptt_pkg::cmp_res_t  cmp
);
    import ptt_pkg::*;

    logic [TW-1:0] diff;

    // Wrap-aware distance to expiry, biased so unsigned order is signed order
    always_comb begin
        diff     = expiry - now;
        key      = {~diff[TW-1], diff[TW-2:0]};
        cmp.due  = (diff == '0) || diff[TW-1];
        cmp.less = key < best_key;
    end

endmodule

`default_nettype wire

FILE: src/ptt_slot_ram.sv
`default_nettype none

module ptt_slot_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 96,
    parameter int AW    = 4
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0]      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: src/periodic_timer_table.sv
// Timer table with one-shot and repeating entries.
// Input channel s_valid/s_ready/s_data carries one request per beat: tick
// (advance time by one), schedule (store a timer in the lowest free slot) or
// cancel (remove the matching entry that expires first). Action code 3 is
// taken and dropped. Output channel m_valid/m_ready/m_data carries results;
// last marks the final result of a request. Schedule and cancel give one
// reply each; a tick gives one expiry per due entry, earliest first, and
// none when nothing is due.
// Every tick, schedule or cancel request walks the slot memory one entry per
// cycle through a single key/compare unit; a tick walks it again after each
// entry that fires. s_ready is high only while no request is in progress.
// A finished result waits in the output register; while the receiver stalls
// the sequencer holds before loading the next result, so nothing is dropped.
// Reset (aresetn low, synchronous) empties the table, sets time to zero and
// clears the output register; no clearing pass is needed.
`default_nettype none

module periodic_timer_table #(
    parameter int NUM_TIMERS = 16,
    parameter int TIME_WIDTH = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire ptt_pkg::in_beat_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output ptt_pkg::out_beat_t     m_data
);
    import ptt_pkg::*;

    localparam int TW  = TIME_WIDTH;
    localparam int N   = NUM_TIMERS;
    localparam int IW  = (N > 1) ? $clog2(N) : 1;
    localparam int CW  = $clog2(N + 1);
    localparam int EW  = ID_W + 2 * TW + REP_W;

    state_t state_reg, state_next;

    in_beat_t          req_reg;
    logic [TW-1:0]     cur_time_reg;
    logic [N-1:0]      valid_reg;
    logic [N-1:0]      fired_reg;
    logic [CW-1:0]     cnt_reg;
    logic              ev_vld_reg;
    logic [IW-1:0]     ev_idx_reg;
    logic              found_reg;
    logic [IW-1:0]     best_idx_reg;
    logic [TW-1:0]     best_key_reg;
    logic [ID_W-1:0]   best_id_reg;
    logic [TW-1:0]     best_exp_reg;
    logic [TW-1:0]     best_per_reg;
    logic [REP_W-1:0]  best_rep_reg;
    logic              pend_vld_reg;
    logic [ID_W-1:0]   pend_id_reg;
    logic              m_valid_reg;
    out_beat_t         m_data_reg;

    logic              s_accept;
    logic              out_free;
    logic              do_decide;
    logic              scan_issue;
    logic              restart;
    logic              cand;
    logic              take;
    logic              out_load;
    out_beat_t         out_beat;

    logic              wr_en;
    logic [EW-1:0]     wr_data;
    logic [EW-1:0]     rd_data;
    logic [ID_W-1:0]   rd_id;
    logic [TW-1:0]     rd_exp;
    logic [TW-1:0]     rd_per;
    logic [REP_W-1:0]  rd_rep;
    logic [TW-1:0]     key;
    cmp_res_t          cmp;
    logic [TW+IN_TIME_W-1:0] exp_ext;
    logic [TW+IN_TIME_W-1:0] per_ext;
    logic [REP_W-1:0]  rep_dec;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign do_decide = (state_reg == ST_DECIDE) && out_free;
    assign scan_issue = (state_reg == ST_SCAN) && (cnt_reg != CW'(N));
    assign restart   = do_decide && (req_reg.action == ACT_TICK) && found_reg;

    // Slot entries: id, expiry, period, repeat
    ptt_slot_ram #(
        .DEPTH(N),
        .WIDTH(EW),
        .AW   (IW)
    ) u_ram (
        .clk    (aclk),
        .wr_en  (wr_en),
        .wr_addr(best_idx_reg),
        .wr_data(wr_data),
        .rd_en  (scan_issue),
        .rd_addr(cnt_reg[IW-1:0]),
        .rd_data(rd_data)
    );

    assign rd_id  = rd_data[EW-1 -: ID_W];
    assign rd_exp = rd_data[2*TW+REP_W-1 -: TW];
    assign rd_per = rd_data[TW+REP_W-1 -: TW];
    assign rd_rep = rd_data[REP_W-1:0];

    ptt_key_unit #(
        .TW(TW)
    ) u_key (
        .expiry  (rd_exp),
        .now     (cur_time_reg),
        .best_key(best_key_reg),
        .key     (key),
        .cmp     (cmp)
    );

    // Fit the 32-bit request times to the table's time width
    assign exp_ext = {{TW{1'b0}}, req_reg.expiry_time};
    assign per_ext = {{TW{1'b0}}, req_reg.period};
    assign rep_dec = best_rep_reg[REP_W-1] ? best_rep_reg : best_rep_reg - 1'b1;

    // Candidate test for the slot whose entry is on the read port
    always_comb begin
        unique case (req_reg.action)
            ACT_TICK:   cand = valid_reg[ev_idx_reg] && !fired_reg[ev_idx_reg] && cmp.due;
            ACT_SCHED:  cand = !valid_reg[ev_idx_reg];
            ACT_CANCEL: cand = valid_reg[ev_idx_reg] && (rd_id == req_reg.timer_id);
            default:    cand = 1'b0;
        endcase
        take = ev_vld_reg && cand &&
               (!found_reg || ((req_reg.action != ACT_SCHED) && cmp.less));
    end

    // Decide step: write back the chosen slot and form the result beat
    always_comb begin
        wr_en    = 1'b0;
        wr_data  = {best_id_reg, best_exp_reg + best_per_reg, best_per_reg, rep_dec};
        out_load = 1'b0;
        out_beat = '{kind: KIND_EXPIRE, timer_id_res: pend_id_reg,
                     status: STATUS_OK, last: 1'b0};
        if (do_decide) begin
            unique case (req_reg.action)
                ACT_TICK: begin
                    wr_en         = found_reg && (best_rep_reg != '0);
                    out_load      = pend_vld_reg;
                    out_beat.last = !found_reg;
                end
                ACT_SCHED: begin
                    wr_en    = found_reg;
                    wr_data  = {req_reg.timer_id, exp_ext[TW-1:0], per_ext[TW-1:0],
                                req_reg.repeat_count};
                    out_load = 1'b1;
                    out_beat = '{kind: KIND_SCHED, timer_id_res: req_reg.timer_id,
                                 status: found_reg ? STATUS_OK : STATUS_FULL,
                                 last: 1'b1};
                end
                ACT_CANCEL: begin
                    out_load = 1'b1;
                    out_beat = '{kind: KIND_CANCEL, timer_id_res: req_reg.timer_id,
                                 status: found_reg ? STATUS_OK : STATUS_MISS,
                                 last: 1'b1};
                end
                default: begin
                    out_load = 1'b0;
                end
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && ((s_data.action == ACT_TICK) ||
                                 (s_data.action == ACT_SCHED) ||
                                 (s_data.action == ACT_CANCEL))) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (cnt_reg == CW'(N)) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (restart) begin
                    state_next = ST_SCAN;
                end else if (do_decide) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Table control: time, valid and fired bits, pending expiry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_time_reg <= '0;
            valid_reg    <= '0;
            fired_reg    <= '0;
            pend_vld_reg <= 1'b0;
        end else begin
            if (s_accept && (s_data.action == ACT_TICK)) begin
                cur_time_reg <= cur_time_reg + 1'b1;
                fired_reg    <= '0;
            end
            if (do_decide) begin
                unique case (req_reg.action)
                    ACT_TICK: begin
                        pend_vld_reg <= found_reg;
                        if (found_reg) begin
                            pend_id_reg             <= best_id_reg;
                            fired_reg[best_idx_reg] <= 1'b1;
                            if (best_rep_reg == '0) begin
                                valid_reg[best_idx_reg] <= 1'b0;
                            end
                        end
                    end
                    ACT_SCHED: begin
                        if (found_reg) begin
                            valid_reg[best_idx_reg] <= 1'b1;
                        end
                    end
                    ACT_CANCEL: begin
                        if (found_reg) begin
                            valid_reg[best_idx_reg] <= 1'b0;
                        end
                    end
                    default: begin
                        pend_vld_reg <= pend_vld_reg;
                    end
                endcase
            end
        end
    end

    // Scan pipeline: issue slot reads, track the best candidate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            ev_vld_reg <= 1'b0;
            found_reg  <= 1'b0;
        end else begin
            if (s_accept || restart) begin
                cnt_reg    <= '0;
                ev_vld_reg <= 1'b0;
                found_reg  <= 1'b0;
            end else begin
                ev_vld_reg <= scan_issue;
                if (scan_issue) begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                if (take) begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    // Scan payload: request, read index and chosen slot fields
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_reg <= s_data;
        end
        if (scan_issue) begin
            ev_idx_reg <= cnt_reg[IW-1:0];
        end
        if (take) begin
            best_idx_reg <= ev_idx_reg;
            best_key_reg <= key;
            best_id_reg  <= rd_id;
            best_exp_reg <= rd_exp;
            best_per_reg <= rd_per;
            best_rep_reg <= rd_rep;
        end
    end

    // Output register: load a result beat, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= out_beat;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Expiry results never carry an error status
    a_expire_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.kind == KIND_EXPIRE) |-> m_data.status == STATUS_OK)
        else $error("expiry beat with nonzero status");

    // Schedule and cancel replies are always the final beat of their request
    a_reply_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.kind != KIND_EXPIRE) |-> m_data.last)
        else $error("reply beat without last");

    // Time moves only after an accepted tick
    a_time_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$stable(cur_time_reg) |->
            $past(s_valid && s_ready && (s_data.action == ACT_TICK)))
        else $error("time advanced without a tick");

    // The output register is never overwritten while a beat is stalled
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !out_load)
        else $error("stalled result overwritten");

endmodule

`default_nettype wire

FILE: tb/ptt_tb_pkg.sv
package ptt_tb_pkg;
    import ptt_pkg::*;

    localparam int TABLE_SLOTS = 16;
    localparam int SHOWN_MISMATCHES = 40;

    // Action code 3 is accepted by the block and dropped
    localparam action_t ACT_SPARE = action_t'(2'd3);

    // Shadow timer table: predicts the result beats of each accepted request
    class timer_scoreboard;
        logic [31:0]        now;
        bit                 slot_busy     [TABLE_SLOTS];
        logic [15:0]        slot_tid      [TABLE_SLOTS];
        logic [31:0]        slot_due_at   [TABLE_SLOTS];
        logic [31:0]        slot_interval [TABLE_SLOTS];
        logic signed [15:0] slot_left     [TABLE_SLOTS];
        out_beat_t          awaited[$];

        int mismatches;
        int n_ticks, n_scheds, n_cancels, n_spare;
        int n_expired, n_full, n_miss, peak_fired;

        function new();
            now = '0;
            foreach (slot_busy[i]) slot_busy[i] = 1'b0;
            mismatches = 0;
            n_ticks = 0; n_scheds = 0; n_cancels = 0; n_spare = 0;
            n_expired = 0; n_full = 0; n_miss = 0; peak_fired = 0;
        endfunction

        // Order key: signed (expiry - now) mapped onto unsigned order
        function logic [31:0] rank(logic [31:0] when);
            return (when - now) ^ 32'h8000_0000;
        endfunction

        function bit overdue(logic [31:0] when);
            logic [31:0] gap;
            gap = when - now;
            return gap == 32'd0 || gap[31];
        endfunction

        function void await_beat(kind_t kind, logic [15:0] tid, status_t status);
            out_beat_t beat;
            beat.kind         = kind;
            beat.timer_id_res = tid;
            beat.status       = status;
            beat.last         = 1'b0;
            awaited.push_back(beat);
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        function int free_slots();
            int n;
            n = 0;
            foreach (slot_busy[i]) if (!slot_busy[i]) n++;
            return n;
        endfunction

        // Id of a random live entry, or a small id when the table is empty
        function logic [15:0] live_id();
            logic [15:0] ids[$];
            foreach (slot_busy[i]) if (slot_busy[i]) ids.push_back(slot_tid[i]);
            if (ids.size() == 0) return 16'($urandom_range(0, 15));
            return ids[$urandom_range(0, ids.size() - 1)];
        endfunction

        // Advance the shadow table by one accepted request beat
        function void note_request(in_beat_t req);
            bit          done[TABLE_SLOTS];
            int          pick;
            int          fired;
            logic [31:0] best;
            fired = 0;
            best  = '0;
            case (req.action)
                ACT_TICK: begin
                    n_ticks++;
                    now = now + 32'd1;
                    foreach (done[i]) done[i] = 1'b0;
                    // fire due entries, earliest first, lowest slot on a tie
                    do begin
                        pick = -1;
                        for (int i = 0; i < TABLE_SLOTS; i++) begin
                            if (slot_busy[i] && !done[i] && overdue(slot_due_at[i])) begin
                                if (pick < 0 || rank(slot_due_at[i]) < best) begin
                                    pick = i;
                                    best = rank(slot_due_at[i]);
                                end
                            end
                        end
                        if (pick >= 0) begin
                            done[pick] = 1'b1;
                            fired++;
                            await_beat(KIND_EXPIRE, slot_tid[pick], STATUS_OK);
                            if (slot_left[pick] == 16'sd0) begin
                                slot_busy[pick] = 1'b0;
                            end else begin
                                if (slot_left[pick] > 16'sd0) slot_left[pick]--;
                                slot_due_at[pick] = slot_due_at[pick] + slot_interval[pick];
                            end
                        end
                    end while (pick >= 0);
                    n_expired += fired;
                    if (fired > peak_fired) peak_fired = fired;
                end
                ACT_SCHED: begin
                    n_scheds++;
                    pick = -1;
                    for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
                        if (!slot_busy[i]) pick = i;
                    end
                    if (pick < 0) begin
                        n_full++;
                        await_beat(KIND_SCHED, req.timer_id, STATUS_FULL);
                    end else begin
                        slot_busy[pick]     = 1'b1;
                        slot_tid[pick]      = req.timer_id;
                        slot_due_at[pick]   = req.expiry_time;
                        slot_interval[pick] = req.period;
                        slot_left[pick]     = req.repeat_count;
                        await_beat(KIND_SCHED, req.timer_id, STATUS_OK);
                    end
                    fired = 1;
                end
                ACT_CANCEL: begin
                    n_cancels++;
                    pick = -1;
                    // drop the matching entry that expires first
                    for (int i = 0; i < TABLE_SLOTS; i++) begin
                        if (slot_busy[i] && slot_tid[i] == req.timer_id) begin
                            if (pick < 0 || rank(slot_due_at[i]) < best) begin
                                pick = i;
                                best = rank(slot_due_at[i]);
                            end
                        end
                    end
                    if (pick >= 0) begin
                        slot_busy[pick] = 1'b0;
                        await_beat(KIND_CANCEL, req.timer_id, STATUS_OK);
                    end else begin
                        n_miss++;
                        await_beat(KIND_CANCEL, req.timer_id, STATUS_MISS);
                    end
                    fired = 1;
                end
                default: n_spare++;
            endcase
            if (fired > 0) awaited[awaited.size() - 1].last = 1'b1;
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= SHOWN_MISMATCHES) $display("mismatch %0d: %s", mismatches, what);
        endtask

        // Compare one result beat with the oldest prediction
        task check_result(out_beat_t got);
            out_beat_t want;
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind=%0d id=%h status=%0d last=%b",
                                          got.kind, got.timer_id_res, got.status, got.last));
                return;
            end
            want = awaited.pop_front();
            if (got.kind !== want.kind)
                report_mismatch($sformatf("kind %0d, want %0d (id %h)",
                                          got.kind, want.kind, want.timer_id_res));
            if (got.timer_id_res !== want.timer_id_res)
                report_mismatch($sformatf("timer id %h, want %h",
                                          got.timer_id_res, want.timer_id_res));
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, want %0d (id %h)",
                                          got.status, want.status, want.timer_id_res));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %b, want %b (id %h)",
                                          got.last, want.last, want.timer_id_res));
        endtask
    endclass

endpackage

FILE: tb/periodic_timer_table_test.sv
module periodic_timer_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ptt_pkg::*;
    import ptt_tb_pkg::*;

    localparam int RANDOM_BEATS   = 310;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_OFF       = 300;
    localparam int HOLD_AT_RESULT = 80;
    localparam int TAIL_CYCLES    = 400;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    bit sender_lazy = 1'b1;

    timer_scoreboard sb = new();

    always #5 aclk = ~aclk;

    periodic_timer_table dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    function automatic in_beat_t make_beat(action_t act, logic [15:0] tid, logic [31:0] when,
                                           logic [31:0] every, logic signed [15:0] times);
        in_beat_t b;
        b.action       = act;
        b.timer_id     = tid;
        b.expiry_time  = when;
        b.period       = every;
        b.repeat_count = times;
        return b;
    endfunction

    // Offer one request beat and hold it until the block takes it
    task automatic push_request(input in_beat_t b);
        int gap;
        gap = sender_lazy ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data  <= b;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Note accepted requests in the scoreboard and check taken results against it
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_request(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
        end
    end

    // Abort when no beat moves for too long
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (aresetn && !(s_valid && s_ready) && !(m_valid && m_ready)) idle++;
            else idle = 0;
        end
        $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("[periodic_timer_table] ERROR");
        $finish;
    end

    // Result sink: random stalls, calm stretches, one long hold-off
    initial begin : sink
        int  stall;
        int  taken;
        bit  lazy;
        bit  held;
        taken = 0;
        lazy  = 1'b1;
        held  = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (taken % 25 == 0) lazy = $urandom_range(0, 3) != 0;
            stall = lazy ? $urandom_range(0, 15) : 0;
            if (!held && taken == HOLD_AT_RESULT) begin
                stall = HOLD_OFF;
                held  = 1'b1;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
        end
    end

    initial begin : stimulus
        in_beat_t b;
        int       counted;
        int       pick;
        int       room;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: miss on empty table, idle tick, extremes, ties, duplicates
        push_request(make_beat(ACT_CANCEL, 16'h0005, 32'd0, 32'd1, 16'sd0));
        push_request(make_beat(ACT_TICK, 16'h0000, 32'd0, 32'd0, 16'sd0));
        push_request(make_beat(ACT_SCHED, 16'h0000, 32'd3, 32'd2, 16'sd1));
        // zero period: re-fires on each following tick until its repeats run out
        push_request(make_beat(ACT_SCHED, 16'hFFFF, 32'd3, 32'd0, 16'sd2));
        push_request(make_beat(ACT_SCHED, 16'h1234, 32'd2, 32'hFFFF_FFFF, -16'sd1));
        // already in the past
        push_request(make_beat(ACT_SCHED, 16'h00AA, 32'hFFFF_FFFF, 32'd1, 16'sd0));
        // half the time range away: counts as due
        push_request(make_beat(ACT_SCHED, 16'h7777, 32'h8000_0001, 32'h8000_0000, 16'sd32767));
        // duplicate ids with equal expiry: cancel takes the lower slot
        push_request(make_beat(ACT_SCHED, 16'h00AA, 32'd5, 32'd1, 16'sd0));
        push_request(make_beat(ACT_SCHED, 16'h00AA, 32'd5, 32'd1, 16'sd0));
        push_request(make_beat(ACT_TICK, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, -16'sd1));
        push_request(make_beat(ACT_CANCEL, 16'h00AA, 32'd0, 32'd1, 16'sd0));
        push_request(make_beat(ACT_CANCEL, 16'h1234, 32'd0, 32'd1, 16'sd0));
        push_request(make_beat(ACT_CANCEL, 16'h7777, 32'd0, 32'd1, 16'sd0));
        push_request(make_beat(ACT_TICK, 16'h0000, 32'd0, 32'd0, 16'sd0));
        push_request(make_beat(ACT_TICK, 16'h0000, 32'd0, 32'd0, 16'sd0));
        push_request(make_beat(ACT_SPARE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, -16'sd1));

        // Fill the table so one tick fires every slot, then overflow it
        s_valid <= 1'b0;
        @(posedge aclk);
        room = sb.free_slots();
        for (int k = 0; k <= room; k++) begin
            push_request(make_beat(ACT_SCHED, 16'h0100 + 16'(k), sb.now + 32'd1,
                                   32'(k), 16'sd0));
        end
        push_request(make_beat(ACT_TICK, 16'h0000, 32'd0, 32'd0, 16'sd0));

        // Random: mostly near-term timers, some wild fields, noise beats
        counted = 0;
        while (counted < RANDOM_BEATS) begin
            if (counted % 40 == 0) sender_lazy = $urandom_range(0, 3) != 0;
            b.timer_id     = 16'($urandom);
            b.expiry_time  = $urandom;
            b.period       = $urandom;
            b.repeat_count = 16'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                b.action = ACT_SPARE;
            end else if (pick < 48) begin
                b.action = ACT_TICK;
            end else if (pick < 78) begin
                b.action = ACT_SCHED;
                if ($urandom_range(0, 9) < 7) b.timer_id = 16'($urandom_range(0, 15));
                pick = $urandom_range(0, 9);
                if (pick < 8) b.expiry_time = sb.now + 32'($urandom_range(0, 24)) - 32'd4;
                else if (pick == 8) b.expiry_time = sb.now + 32'h7FFF_FFFF
                                                    + 32'($urandom_range(0, 2));
                pick = $urandom_range(0, 19);
                if (pick < 15) b.period = 32'($urandom_range(1, 8));
                else if (pick < 17) b.period = 32'd0;
                else if (pick == 17) b.period = 32'hFFFF_FFFF;
                pick = $urandom_range(0, 19);
                if (pick < 9) b.repeat_count = 16'sd0;
                else if (pick < 16) b.repeat_count = 16'($urandom_range(1, 4));
                else if (pick < 18) b.repeat_count = -16'sd1;
                else if (pick == 18) b.repeat_count = 16'($urandom_range(5, 32767));
            end else begin
                b.action = ACT_CANCEL;
                if ($urandom_range(0, 9) != 0) b.timer_id = sb.live_id();
            end
            push_request(b);
            if (b.action != ACT_SPARE) counted++;
        end
        s_valid <= 1'b0;

        // Drain outstanding results, then let a trailing quiet tick finish
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d ticks, %0d schedules, %0d cancels, %0d dropped beats",
                 sb.n_ticks, sb.n_scheds, sb.n_cancels, sb.n_spare);
        $display("saw %0d expirations (up to %0d in one tick), %0d full, %0d cancel misses",
                 sb.n_expired, sb.peak_fired, sb.n_full, sb.n_miss);
        if (sb.mismatches == 0) begin
            $display("[periodic_timer_table] OK");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("[periodic_timer_table] ERROR");
        end
        $finish;
    end

endmodule
